// ===== hdl/hmng_pkg.sv =====
// ----------------------------------------------------------------------------
// hmng_pkg
// Shared constants for the heightmap normal generator: defaults, register
// indexes, request kinds and fixed-point scale points.
// ----------------------------------------------------------------------------
package hmng_pkg;

  // Default grid store geometry and stored height width
  localparam int DEFAULT_MAX_COLS    = 256;
  localparam int DEFAULT_MAX_ROWS    = 256;
  localparam int DEFAULT_HEIGHT_BITS = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 2'd1;

  // Grid size register width and reset value before clamping
  localparam int SIZE_W     = 9;
  localparam int SIZE_RESET = 256;

  // Request kinds carried on tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Fixed-point points
  localparam int ONE_Q14   = 16384;  // 1.0 in Q1.14
  localparam int TWO_Q8_8  = 512;    // 2.0 in Q8.8
  localparam int MAG_BITS  = 24;     // magnitudes brought below 2^24
  localparam int Q_BITS    = 15;     // quotient bits per component
  localparam int ROOT_BITS = 31;     // floor(sqrt(S * 4096)) < 2^31

endpackage

// ===== hdl/hmng_ram.sv =====
// ----------------------------------------------------------------------------
// hmng_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module hmng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/heightmap_normal_generator.sv =====
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Terrain height grid with a central-difference surface normal query.
// ----------------------------------------------------------------------------
// A write request (tuser = 0) stores one signed Q8.8 height at (col, row);
// writes outside the configured grid size are dropped and give no result. A
// query request (tuser = 1) reads the left, right, down and up neighbours
// (coordinates clamped to the grid), forms (L-R, 2.0, D-U) and returns it
// scaled to unit length as three Q1.14 components. The query time is set by
// the 32-step square root and the three 15-step divisions, which all run
// through one shared 64-bit subtractor, and can grow when stored heights
// exceed 24 bits; the four neighbour reads share the one read port of the
// height RAM. The input side is not ready while a query is in progress. A
// finished result sits in the output register, so the next request is taken
// while it waits. The height RAM is not cleared: a query must only touch
// cells that have been written.
// ----------------------------------------------------------------------------
module heightmap_normal_generator
  import hmng_pkg::*;
#(
  parameter int MAX_COLS    = DEFAULT_MAX_COLS,
  parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
  parameter int HEIGHT_BITS = DEFAULT_HEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // col[7:0], row[15:8], height[31:16]
  input  logic                   s_tuser,   // mode[0]
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [47:0]            m_tdata,   // normal_x[15:0], normal_y[30:16],
                                            // normal_z[46:31], zero pad[47]
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DIFF_W     = HEIGHT_BITS + 1;
  localparam int MW         = (HEIGHT_BITS > MAG_BITS) ? HEIGHT_BITS : MAG_BITS;
  localparam int COLS_RESET = (MAX_COLS < SIZE_RESET) ? MAX_COLS : SIZE_RESET;
  localparam int ROWS_RESET = (MAX_ROWS < SIZE_RESET) ? MAX_ROWS : SIZE_RESET;
  localparam int PROD_W     = 2 * MAG_BITS;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NUM_W      = MAG_BITS + 21;  // m * 2^20 + r/2

  localparam logic signed [32:0] HMAX = (33'sd1 <<< (HEIGHT_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] HMIN = -HMAX - 33'sd1;

  // Sequencer, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_READ   = 9'b000000010,
    ST_DIFF   = 9'b000000100,
    ST_SHIFT  = 9'b000001000,
    ST_SQUARE = 9'b000010000,
    ST_ROOT   = 9'b000100000,
    ST_DIVLD  = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [SIZE_W-1:0] size_clamp(logic [SIZE_W-1:0] v, int maxv);
    if (v == '0) return SIZE_W'(1);
    if (int'(v) > maxv) return SIZE_W'(maxv);
    return v;
  endfunction

  // clamp a signed coordinate into 0 .. size-1
  function automatic logic [SIZE_W-1:0] clamp_coord(logic signed [SIZE_W:0] v,
                                                   logic [SIZE_W-1:0] size);
    logic signed [SIZE_W:0] hi;
    hi = signed'({1'b0, size - SIZE_W'(1)});
    if (v < 0) return '0;
    if (v > hi) return hi[SIZE_W-1:0];
    return v[SIZE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [SIZE_W-1:0] cc,
                                                 logic [SIZE_W-1:0] rr);
    return ADDR_W'(rr) * ADDR_W'(MAX_COLS) + ADDR_W'(cc);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                   state;
  logic [SIZE_W-1:0]        cols, rows;
  logic [4:0]               step;
  logic [1:0]               comp;
  logic [7:0]               qcol, qrow;
  logic [HEIGHT_BITS-1:0]   hl, hr, hd, hu;
  logic [MW-1:0]            mx, mz;
  logic [9:0]               my;
  logic                     sx, sz;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         acc;
  logic [63:0]              rad;      // square root remainder
  logic [63:0]              res;      // square root partial result
  logic [ROOT_BITS-1:0]     root;
  logic [ROOT_BITS-1:0]     rem;      // divider remainder
  logic [Q_BITS-1:0]        low;      // numerator bits still to bring down
  logic [Q_BITS-1:0]        quo;
  logic [15:0]              normal_x;
  logic [14:0]              normal_y;
  logic [15:0]              normal_z;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                   s_accept;
  logic [7:0]             in_col, in_row;
  logic signed [32:0]     h_ext, h_sat;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign in_col    = s_tdata[7:0];
  assign in_row    = s_tdata[15:8];
  assign h_ext     = {{17{s_tdata[31]}}, s_tdata[31:16]};
  assign h_sat     = (h_ext > HMAX) ? HMAX : ((h_ext < HMIN) ? HMIN : h_ext);
  assign wr_en     = s_accept && (s_tuser == MODE_WRITE) &&
                     ({1'b0, in_col} < cols) && ({1'b0, in_row} < rows);
  assign wr_addr   = cell_addr({1'b0, in_col}, {1'b0, in_row});

  // --------------------------------------------------------------------------
  // Neighbour reads: left, right, down, up on steps 0..3, data one step later
  // --------------------------------------------------------------------------
  logic signed [SIZE_W:0] qc_s, qr_s;
  logic [SIZE_W-1:0]      rd_c, rd_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic [HEIGHT_BITS-1:0] rd_data;

  assign qc_s = signed'({2'b00, qcol});
  assign qr_s = signed'({2'b00, qrow});

  always_comb begin
    case (step[1:0])
      2'd0: begin
        rd_c = clamp_coord(qc_s - 10'sd1, cols);
        rd_r = clamp_coord(qr_s, rows);
      end
      2'd1: begin
        rd_c = clamp_coord(qc_s + 10'sd1, cols);
        rd_r = clamp_coord(qr_s, rows);
      end
      2'd2: begin
        rd_c = clamp_coord(qc_s, cols);
        rd_r = clamp_coord(qr_s - 10'sd1, rows);
      end
      default: begin
        rd_c = clamp_coord(qc_s, cols);
        rd_r = clamp_coord(qr_s + 10'sd1, rows);
      end
    endcase
  end

  assign rd_addr = cell_addr(rd_c, rd_r);

  hmng_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_height_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (h_sat[HEIGHT_BITS-1:0]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Differences and magnitudes
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dx, dz;
  logic [DIFF_W-1:0]        dx_mag, dz_mag;
  logic                     too_big;

  assign dx     = signed'({hl[HEIGHT_BITS-1], hl}) - signed'({hr[HEIGHT_BITS-1], hr});
  assign dz     = signed'({hd[HEIGHT_BITS-1], hd}) - signed'({hu[HEIGHT_BITS-1], hu});
  assign dx_mag = dx[DIFF_W-1] ? (DIFF_W'(0) - dx) : dx;
  assign dz_mag = dz[DIFF_W-1] ? (DIFF_W'(0) - dz) : dz;
  assign too_big = ((mx >> MAG_BITS) != '0) || ((mz >> MAG_BITS) != '0);

  // component select: 0 x, 1 y, 2 z
  logic [1:0]          msel;
  logic [MAG_BITS-1:0] mop;

  assign msel = (state == ST_SQUARE) ? step[1:0] : comp;

  always_comb begin
    case (msel)
      2'd0:    mop = mx[MAG_BITS-1:0];
      2'd1:    mop = MAG_BITS'(my);
      default: mop = mz[MAG_BITS-1:0];
    endcase
  end

  logic [ACC_W-1:0] acc_sum;
  assign acc_sum = acc + ACC_W'(prod);

  // --------------------------------------------------------------------------
  // Shared subtractor: square root trial and division trial
  // --------------------------------------------------------------------------
  logic [63:0] root_bit, res_next;
  logic [31:0] div_shift;
  logic [63:0] sub_a, sub_b;
  logic [64:0] sub_diff;
  logic        sub_borrow;

  assign root_bit  = 64'd1 << {step, 1'b0};
  assign div_shift = {rem, low[Q_BITS-1]};

  always_comb begin
    case (state)
      ST_ROOT: begin
        sub_a = rad;
        sub_b = res | root_bit;
      end
      ST_DIV: begin
        sub_a = 64'(div_shift);
        sub_b = 64'(root);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[64];
  assign res_next   = sub_borrow ? (res >> 1) : ((res >> 1) + root_bit);

  // division numerator m * 2^20 + r/2, and the finished quotient
  logic [NUM_W-1:0]  num;
  logic [Q_BITS-1:0] quo_next, q_sat;
  logic [15:0]       q_ext;

  assign num      = {1'b0, mop, 20'd0} + NUM_W'(root >> 1);
  assign quo_next = {quo[Q_BITS-2:0], ~sub_borrow};
  assign q_sat    = (quo_next > Q_BITS'(ONE_Q14)) ? Q_BITS'(ONE_Q14) : quo_next;
  assign q_ext    = {1'b0, q_sat};

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= SIZE_W'(COLS_RESET);
      rows <= SIZE_W'(ROWS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_COLUMNS: cols <= size_clamp(cfg_data, MAX_COLS);
        REG_GRID_ROWS:    rows <= size_clamp(cfg_data, MAX_ROWS);
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      comp  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_accept && (s_tuser == MODE_QUERY)) begin
            step  <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          step <= step + 5'd1;
          if (step == 5'd4) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF:  state <= ST_SHIFT;
        ST_SHIFT: begin
          if (!too_big) begin
            step  <= '0;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          step <= step + 5'd1;
          if (step == 5'd3) begin
            step  <= 5'd31;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          step <= step - 5'd1;
          if (step == 5'd0) begin
            comp  <= '0;
            state <= ST_DIVLD;
          end
        end
        ST_DIVLD: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 5'd1;
          if (step == 5'(Q_BITS - 1)) begin
            comp  <= comp + 2'd1;
            state <= (comp == 2'd2) ? ST_DONE : ST_DIVLD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qcol <= in_col;
        qrow <= in_row;
      end
      ST_READ: begin
        case (step)
          5'd1:    hl <= rd_data;
          5'd2:    hr <= rd_data;
          5'd3:    hd <= rd_data;
          5'd4:    hu <= rd_data;
          default: ;
        endcase
      end
      ST_DIFF: begin
        mx <= MW'(dx_mag[HEIGHT_BITS-1:0]);
        mz <= MW'(dz_mag[HEIGHT_BITS-1:0]);
        my <= 10'(TWO_Q8_8);
        sx <= dx[DIFF_W-1];
        sz <= dz[DIFF_W-1];
      end
      ST_SHIFT: begin
        if (too_big) begin
          mx <= mx >> 1;
          my <= my >> 1;
          mz <= mz >> 1;
        end
      end
      ST_SQUARE: begin
        prod <= mop * mop;
        if (step == 5'd0) begin
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
        if (step == 5'd3) begin
          rad <= 64'({acc_sum, 12'd0});
          res <= '0;
        end
      end
      ST_ROOT: begin
        if (!sub_borrow) begin
          rad <= sub_diff[63:0];
        end
        res <= res_next;
        if (step == 5'd0) begin
          root <= res_next[ROOT_BITS-1:0];
        end
      end
      ST_DIVLD: begin
        rem <= ROOT_BITS'(num[NUM_W-1:Q_BITS]);
        low <= num[Q_BITS-1:0];
        quo <= '0;
      end
      ST_DIV: begin
        rem <= sub_borrow ? div_shift[ROOT_BITS-1:0] : sub_diff[ROOT_BITS-1:0];
        low <= low << 1;
        quo <= quo_next;
        if (step == 5'(Q_BITS - 1)) begin
          case (comp)
            2'd0:    normal_x <= sx ? (16'd0 - q_ext) : q_ext;
            2'd1:    normal_y <= q_sat;
            default: normal_z <= sz ? (16'd0 - q_ext) : q_ext;
          endcase
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, normal_z, normal_y, normal_x};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_tuser == MODE_WRITE)) |=> (state == ST_IDLE))
    else $error("write request started a query sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result appeared outside the done step");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVLD) |-> (root >= ROOT_BITS'(64)))
    else $error("square root below the 2.0 floor");

  a_grid_range: assert property (@(posedge clk) disable iff (rst)
    (cols != '0) && (int'(cols) <= MAX_COLS) && (rows != '0) && (int'(rows) <= MAX_ROWS))
    else $error("grid size register out of range");

  a_normal_y_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:16] <= 15'(ONE_Q14)))
    else $error("y component above 1.0");

endmodule
